// File: design/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg - shared types and constants of the chained hash table
// Pool and bucket sizes, field widths, result codes and request/result structs.
// ----------------------------------------------------------------------------
package cht_pkg;

	localparam int MAX_BUCKETS = 64;
	localparam int NODE_POOL   = 256;

	localparam int KEY_W  = 31;
	localparam int BKT_W  = $clog2(MAX_BUCKETS);
	localparam int DIV_W  = $clog2(MAX_BUCKETS + 1);
	localparam int NODE_W = $clog2(NODE_POOL);
	localparam int LINK_W = $clog2(NODE_POOL + 1);
	localparam int CNT_W  = $clog2(NODE_POOL + 1);
	localparam int POS_W  = 8;
	localparam int CFG_W  = 7;
	localparam int NREC_W = KEY_W + LINK_W;

	localparam logic [LINK_W-1:0] EMPTY_MARK    = LINK_W'(NODE_POOL);
	localparam logic [CFG_W-1:0]  BUCKETS_RESET = CFG_W'(7);

	typedef enum logic [0:0] {
		OP_INSERT = 1'b0,
		OP_SEARCH = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_FOUND     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_POOL_FULL = 2'd3
	} status_t;

	typedef struct packed {
		op_t              operation;
		logic [KEY_W-1:0] key;
	} cht_req_t;

	typedef struct packed {
		status_t          status;
		logic [BKT_W-1:0] bucket;
		logic [POS_W-1:0] chain_position;
	} cht_rsp_t;

endpackage

// File: design/cht_ram.sv
// ----------------------------------------------------------------------------
// cht_ram - simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module cht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/cht_div.sv
// ----------------------------------------------------------------------------
// cht_div - bit-serial modulo unit
// Restoring remainder of the key by the bucket count, one key bit per cycle.
// ----------------------------------------------------------------------------
module cht_div import cht_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [KEY_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             done,
	output logic [BKT_W-1:0] remainder
);

	localparam int STEP_W = $clog2(KEY_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [KEY_W-1:0]  dvd_q;
	logic [BKT_W-1:0]  rem_q;
	logic [DIV_W-1:0]  divisor_q;
	logic [DIV_W-1:0]  trial;

	// shift in the next key bit; remainder stays below the divisor
	assign trial = {rem_q, dvd_q[KEY_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(KEY_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q     <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[KEY_W-2:0], 1'b0};
			if (trial >= divisor_q) begin
				rem_q <= BKT_W'(trial - divisor_q);
			end else begin
				rem_q <= BKT_W'(trial);
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// File: design/chained_hash_table_unit.sv
// ----------------------------------------------------------------------------
// chained_hash_table_unit - hash table with separate chaining, modulo hash
// Each request passes the bit-serial modulo unit, then a head read and, for a
// search, one node read per chain node visited, before the result is loaded.
// One request at a time; the next is accepted in the cycle after the result
// is loaded, even while that result waits.
// Reset: asynchronous, active low; all bucket heads empty at once through
// per-bucket valid flags, pool emptied, bucket count back to 7. No clear pass.
// ----------------------------------------------------------------------------
module chained_hash_table_unit import cht_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        req_valid,
	output logic        req_ready,
	input  cht_req_t    req,
	// result channel
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output cht_rsp_t    rsp,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// register index lives in the word address bit
	localparam logic [0:0] REG_BUCKET_COUNT = 1'b0;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_DIV  = 5'b00010,
		S_HEAD = 5'b00100,
		S_NODE = 5'b01000,
		S_RESP = 5'b10000
	} state_t;

	state_t              state_q;
	logic [CFG_W-1:0]    bucket_count_q;
	logic [DIV_W-1:0]    eff_buckets;
	op_t                 op_q;
	logic [KEY_W-1:0]    key_q;
	logic [CNT_W-1:0]    used_q;
	logic [CNT_W-1:0]    steps_q;
	status_t             status_q;
	logic [POS_W-1:0]    pos_q;
	logic                rsp_valid_q;
	cht_rsp_t            rsp_q;

	logic [MAX_BUCKETS-1:0] head_valid_q;
	logic                   head_vld_s1;

	logic                div_start;
	logic                div_done;
	logic [BKT_W-1:0]    bucket;

	logic                head_we;
	logic [LINK_W-1:0]   head_rdata;
	logic [LINK_W-1:0]   head_eff;
	logic                node_we;
	logic [NREC_W-1:0]   node_wdata;
	logic [NREC_W-1:0]   node_rdata;
	logic [KEY_W-1:0]    node_key;
	logic [LINK_W-1:0]   node_link;

	logic [LINK_W-1:0]   cur_cand;
	logic [CNT_W-1:0]    steps_cand;
	logic                walk_ok;
	logic                key_match;
	logic                pool_full;
	logic                accept;
	logic                rsp_load;
	logic                cfg_write;

	// ---------------------------------------------------------------- config
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_BUCKET_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= BUCKETS_RESET;
		end else if (cfg_write) begin
			bucket_count_q <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_BUCKET_COUNT) begin
			prdata = 32'(bucket_count_q);
		end
	end

	// clamp divisor: zero acts as one, saturate at the bucket table size
	always_comb begin
		if (bucket_count_q == '0) begin
			eff_buckets = DIV_W'(1);
		end else if (32'(bucket_count_q) > MAX_BUCKETS) begin
			eff_buckets = DIV_W'(MAX_BUCKETS);
		end else begin
			eff_buckets = DIV_W'(bucket_count_q);
		end
	end

	// ---------------------------------------------------------------- modulo
	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == S_IDLE);
	assign div_start = accept;

	cht_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (req.key),
		.divisor   (eff_buckets),
		.done      (div_done),
		.remainder (bucket)
	);

	// ---------------------------------------------------------------- memories
	// The remainder is held steady from the divider's done pulse until the next
	// request, so the head read address needs no register of its own. Writes
	// happen only in S_HEAD of an insert and the next read of any entry comes
	// at least a full modulo pass later: no overlap, no forwarding needed.
	cht_ram #(
		.WIDTH (LINK_W),
		.DEPTH (MAX_BUCKETS)
	) u_heads (
		.clk   (clk),
		.we    (head_we),
		.waddr (bucket),
		.wdata (used_q),
		.raddr (bucket),
		.rdata (head_rdata)
	);

	// sample the head flag alongside the RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_s1 <= 1'b0;
		end else begin
			head_vld_s1 <= head_valid_q[bucket];
		end
	end

	assign head_eff = head_vld_s1 ? head_rdata : EMPTY_MARK;

	cht_ram #(
		.WIDTH (NREC_W),
		.DEPTH (NODE_POOL)
	) u_nodes (
		.clk   (clk),
		.we    (node_we),
		.waddr (used_q[NODE_W-1:0]),
		.wdata (node_wdata),
		.raddr (cur_cand[NODE_W-1:0]),
		.rdata (node_rdata)
	);

	assign node_wdata = {key_q, head_eff};
	assign node_key   = node_rdata[NREC_W-1:LINK_W];
	assign node_link  = node_rdata[LINK_W-1:0];

	// ---------------------------------------------------------------- walk
	// Candidate node: the bucket head on the first step, then the link of the
	// node just read. Stop on a key match, at a link outside the filled pool or
	// after as many steps as there are nodes.
	always_comb begin
		if (state_q == S_HEAD) begin
			cur_cand   = head_eff;
			steps_cand = '0;
		end else begin
			cur_cand   = node_link;
			steps_cand = steps_q + CNT_W'(1);
		end
		walk_ok   = (cur_cand < used_q) && (steps_cand < used_q);
		key_match = (node_key == key_q);
	end

	assign pool_full = (used_q >= CNT_W'(NODE_POOL));
	assign head_we   = (state_q == S_HEAD) && (op_q == OP_INSERT) && !pool_full;
	assign node_we   = head_we;

	// load the result once the output register is free
	assign rsp_load = (state_q == S_RESP) && (!rsp_valid_q || rsp_ready);

	// ---------------------------------------------------------------- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			used_q       <= '0;
			head_valid_q <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					if (op_q == OP_INSERT) begin
						state_q <= S_RESP;
						if (!pool_full) begin
							used_q               <= used_q + CNT_W'(1);
							head_valid_q[bucket] <= 1'b1;
						end
					end else if (walk_ok) begin
						state_q <= S_NODE;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_NODE: begin
					if (key_match || !walk_ok) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					// hold the result until the output register is free
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req.operation;
			key_q <= req.key;
		end
		unique case (state_q)
			S_HEAD: begin
				steps_q <= steps_cand;
				pos_q   <= '0;
				if (op_q == OP_INSERT) begin
					status_q <= pool_full ? ST_POOL_FULL : ST_INSERTED;
				end else begin
					status_q <= ST_NOT_FOUND;
				end
			end
			S_NODE: begin
				if (key_match) begin
					status_q <= ST_FOUND;
					// saturate the chain depth at the field range
					pos_q <= (steps_q > CNT_W'(2**POS_W - 1)) ? '1 : steps_q[POS_W-1:0];
				end else begin
					steps_q <= steps_cand;
				end
			end
			S_RESP: begin
				if (rsp_load) begin
					rsp_q.status         <= status_q;
					rsp_q.bucket         <= bucket;
					rsp_q.chain_position <= pos_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
